FILE: hw/rtl/planar_rect_span_mask_generator_defines.svh
// Assertion macros shared by the span mask generator RTL.
`ifndef PLANAR_RECT_SPAN_MASK_GENERATOR_DEFINES_SVH
`define PLANAR_RECT_SPAN_MASK_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property at every clock edge outside reset.
`define PRSM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every clock edge, reset included.
`define PRSM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PRSM_ASSERT(label, clk, rst, prop, msg)
`define PRSM_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

FILE: hw/rtl/prsm_pkg.sv
// Types and constants of the planar span mask generator.
package prsm_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_STRIDE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;

  localparam logic [7:0]  STRIDE_RESET = 8'd80;
  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [10:0] HEIGHT_RESET = 11'd480;

  localparam logic [7:0] MASK_FULL    = 8'hFF;
  localparam logic [3:0] COLOR_INVERT = 4'hF;
  localparam logic [3:0] PIXELS_PER_BYTE = 4'd8;

  localparam logic REQ_FILL   = 1'b0;
  localparam logic REQ_INVERT = 1'b1;

  // One-hot part selects, in emission order.
  localparam logic [2:0] PART_NONE  = 3'b000;
  localparam logic [2:0] PART_LEFT  = 3'b001;
  localparam logic [2:0] PART_MID   = 3'b010;
  localparam logic [2:0] PART_RIGHT = 3'b100;

  typedef struct packed {
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

  typedef struct packed {
    logic       req_type;
    logic [9:0] x_start;
    logic [9:0] x_end;
    logic [9:0] row;
    logic [3:0] color;
  } span_req_t;

  typedef struct packed {
    logic [16:0] byte_offset;
    logic [7:0]  bit_mask;
    logic [7:0]  run_bytes;
    logic        read_first;
    logic        write_op;
    logic [3:0]  out_color;
    logic        range_error;
    logic        last;
  } span_result_t;

  // Classified span as handed from the front to the back.
  typedef struct packed {
    logic        range_error;
    logic        write_op;
    logic [3:0]  out_color;
    logic [16:0] base_off;
    logic [2:0]  part_v;
    logic [7:0]  left_mask;
    logic [7:0]  mid_run;
    logic        mid_rd;
    logic [7:0]  right_mask;
  } span_cmd_t;

endpackage

FILE: hw/rtl/planar_rect_span_mask_generator.sv
// Top level of the planar span mask generator.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------
//  span in  | push / full        | span   (prsm_pkg::span_req_t)
//  result   | pop / empty        | result (prsm_pkg::span_result_t)
//  config   | cfg_wr_en          | cfg_index, cfg_data
//
// The front classifies a span combinationally into the command queue; the back then
// emits one write command per part, one per cycle while the result queue is not full.
// The command queue holds CMD_DEPTH classified spans; the result queue holds
// OUT_DEPTH results, so spans keep entering while results wait to be popped.
// Reset (synchronous) restores the register defaults and empties both queues.
// full rises when the command queue is full; a stalled result queue stalls the back.
module planar_rect_span_mask_generator #(
  parameter int CMD_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [prsm_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [prsm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   push,
  output logic                                   full,
  input  prsm_pkg::span_req_t                    span,
  input  logic                                   pop,
  output logic                                   empty,
  output prsm_pkg::span_result_t                 result
);

  prsm_pkg::cfg_write_t   cfg;
  prsm_pkg::span_cmd_t    cmd_in;
  prsm_pkg::span_cmd_t    cmd_out;
  prsm_pkg::span_result_t res;
  logic                   cmd_push;
  logic                   cmd_pop;
  logic                   cmd_empty;
  logic                   res_push;
  logic                   res_full;

  assign cfg.wr_en = cfg_wr_en;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  prsm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .span     (span),
    .cmd_full (full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  prsm_fifo #(
    .WIDTH ($bits(prsm_pkg::span_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .wr_data (cmd_in),
    .full    (full),
    .pop     (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  prsm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  prsm_fifo #(
    .WIDTH ($bits(prsm_pkg::span_result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

FILE: hw/rtl/prsm_fifo.sv
// Small register queue with count-based full and empty flags.
`include "planar_rect_span_mask_generator_defines.svh"

module prsm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  `PRSM_ASSERT(a_fifo_count_bound, clk, rst, count <= CNT_W'(DEPTH), "fifo count exceeds depth")
  `PRSM_ASSERT(a_fifo_ptr_track, clk, rst, (count == '0) |-> (wr_ptr == rd_ptr), "empty fifo with unequal pointers")

endmodule

FILE: hw/rtl/prsm_front.sv
// Front end: configuration registers, range check and span classification.
`include "planar_rect_span_mask_generator_defines.svh"

module prsm_front (
  input  logic                  clk,
  input  logic                  rst,
  input  prsm_pkg::cfg_write_t  cfg,
  input  logic                  push,
  input  prsm_pkg::span_req_t   span,
  input  logic                  cmd_full,
  output logic                  cmd_push,
  output prsm_pkg::span_cmd_t   cmd
);

  logic [7:0]  line_stride_bytes;
  logic [10:0] screen_width;
  logic [10:0] screen_height;

  logic        bad;
  logic        inv;
  logic [10:0] width;
  logic [2:0]  left;
  logic [2:0]  right;
  logic        left_only;
  logic [10:0] mid_span;
  logic [7:0]  mid;
  logic [17:0] prod;
  logic [16:0] off;
  logic [7:0]  lmask;
  logic [2:0]  lw;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_stride_bytes <= prsm_pkg::STRIDE_RESET;
      screen_width      <= prsm_pkg::WIDTH_RESET;
      screen_height     <= prsm_pkg::HEIGHT_RESET;
    end else if (cfg.wr_en) begin
      case (cfg.index)
        prsm_pkg::CFG_LINE_STRIDE:   line_stride_bytes <= cfg.data[7:0];
        prsm_pkg::CFG_SCREEN_WIDTH:  screen_width      <= cfg.data;
        prsm_pkg::CFG_SCREEN_HEIGHT: screen_height     <= cfg.data;
        default: ;
      endcase
    end
  end

  assign cmd_push = push && !cmd_full;

  always_comb begin
    bad = ({1'b0, span.x_start} >= screen_width) ||
          ({1'b0, span.x_end} >= screen_width) ||
          ({1'b0, span.row} >= screen_height) ||
          (span.x_start > span.x_end);
    inv   = (span.req_type == prsm_pkg::REQ_INVERT);
    width = 11'(11'({1'b0, span.x_end} - {1'b0, span.x_start}) + 11'd1);
    // pixels up to the next byte boundary
    left  = 3'(3'd0 - span.x_start[2:0]);
    right = 3'(span.x_end[2:0] + 3'd1);
    left_only = ({8'd0, left} >= width);
    mid_span  = 11'(width - {8'd0, left} - {8'd0, right});
    mid       = mid_span[10:3];
    prod  = 18'(span.row * line_stride_bytes);
    off   = 17'(prod + 18'(span.x_start[9:3]));
    lmask = prsm_pkg::MASK_FULL >> (prsm_pkg::PIXELS_PER_BYTE - {1'b0, left});
    lw    = 3'(left - width[2:0]);
    // span ends inside the first byte: trim the right side too
    if ({8'd0, left} > width) begin
      lmask = lmask & 8'(prsm_pkg::MASK_FULL << lw);
    end

    cmd = '0;
    if (bad) begin
      cmd.range_error = 1'b1;
      cmd.part_v      = prsm_pkg::PART_LEFT;
    end else begin
      cmd.write_op   = inv;
      cmd.out_color  = inv ? prsm_pkg::COLOR_INVERT : span.color;
      cmd.base_off   = off;
      cmd.left_mask  = lmask;
      cmd.mid_run    = mid;
      cmd.mid_rd     = inv;
      cmd.right_mask = 8'(prsm_pkg::MASK_FULL << (prsm_pkg::PIXELS_PER_BYTE - {1'b0, right}));
      cmd.part_v[0]  = (left != 3'd0);
      cmd.part_v[1]  = !left_only && (mid != 8'd0);
      cmd.part_v[2]  = !left_only && (right != 3'd0);
    end
  end

  `PRSM_ASSERT(a_front_parts, clk, rst, cmd_push |-> (cmd.part_v != prsm_pkg::PART_NONE), "classified span has no part")

endmodule

FILE: hw/rtl/prsm_back.sv
// Back end: walks the parts of each classified span and emits write commands.
`include "planar_rect_span_mask_generator_defines.svh"

module prsm_back (
  input  logic                   clk,
  input  logic                   rst,
  input  prsm_pkg::span_cmd_t    cmd,
  input  logic                   cmd_empty,
  output logic                   cmd_pop,
  input  logic                   res_full,
  output logic                   res_push,
  output prsm_pkg::span_result_t res
);

  logic [2:0]  done;
  logic [2:0]  pending;
  logic [2:0]  sel;
  logic        more;
  logic        emit;
  logic [16:0] run_off;
  logic [16:0] cur_off;

  always_comb begin
    pending = cmd.part_v & ~done;
    // lowest pending part goes first
    sel     = pending & 3'(~pending + 3'd1);
    more    = |(pending & ~sel);
    emit    = !cmd_empty && !res_full;
    cur_off = (done == prsm_pkg::PART_NONE) ? cmd.base_off : run_off;

    res             = '0;
    res.byte_offset = cur_off;
    res.write_op    = cmd.write_op;
    res.out_color   = cmd.out_color;
    res.range_error = cmd.range_error;
    res.last        = !more;
    case (sel)
      prsm_pkg::PART_LEFT: begin
        res.bit_mask   = cmd.left_mask;
        res.run_bytes  = cmd.range_error ? 8'd0 : 8'd1;
        res.read_first = !cmd.range_error;
      end
      prsm_pkg::PART_MID: begin
        res.bit_mask   = prsm_pkg::MASK_FULL;
        res.run_bytes  = cmd.mid_run;
        res.read_first = cmd.mid_rd;
      end
      prsm_pkg::PART_RIGHT: begin
        res.bit_mask   = cmd.right_mask;
        res.run_bytes  = 8'd1;
        res.read_first = 1'b1;
      end
      default: begin
        res.bit_mask   = 8'd0;
        res.run_bytes  = 8'd0;
        res.read_first = 1'b0;
      end
    endcase
  end

  assign res_push = emit;
  assign cmd_pop  = emit && !more;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= prsm_pkg::PART_NONE;
    end else if (emit) begin
      done <= more ? (done | sel) : prsm_pkg::PART_NONE;
    end
  end

  // advance the offset past the bytes just covered
  always_ff @(posedge clk) begin
    if (emit) begin
      run_off <= 17'(cur_off + 17'(res.run_bytes));
    end
  end

  `PRSM_ASSERT(a_back_pending, clk, rst, !cmd_empty |-> (pending != prsm_pkg::PART_NONE), "queued span with no part left")
  `PRSM_ASSERT(a_back_err_last, clk, rst, (res_push && res.range_error) |-> res.last, "error result not marked last")

endmodule
